/* hdl/lcsr_pkg.sv */
`default_nettype none

package lcsr_pkg;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_RX    = 2'd2,
        KIND_TX    = 2'd3
    } kind_t;

    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_ADDR = 1'b1;

    localparam logic [1:0] EV_DONE  = 2'd0;
    localparam logic [1:0] EV_MISS  = 2'd1;
    localparam logic [1:0] EV_ABORT = 2'd2;

    localparam logic [1:0] CSR0 = 2'd0;
    localparam logic [1:0] CSR1 = 2'd1;
    localparam logic [1:0] CSR2 = 2'd2;
    localparam logic [1:0] CSR3 = 2'd3;

    // CSR0 bits
    localparam logic [15:0] S0_ERR  = 16'h8000;
    localparam logic [15:0] S0_BABL = 16'h4000;
    localparam logic [15:0] S0_CERR = 16'h2000;
    localparam logic [15:0] S0_MISS = 16'h1000;
    localparam logic [15:0] S0_MERR = 16'h0800;
    localparam logic [15:0] S0_RINT = 16'h0400;
    localparam logic [15:0] S0_TINT = 16'h0200;
    localparam logic [15:0] S0_IDON = 16'h0100;
    localparam logic [15:0] S0_INTR = 16'h0080;
    localparam logic [15:0] S0_INEA = 16'h0040;
    localparam logic [15:0] S0_RXON = 16'h0020;
    localparam logic [15:0] S0_TXON = 16'h0010;
    localparam logic [15:0] S0_TDMD = 16'h0008;
    localparam logic [15:0] S0_STOP = 16'h0004;
    localparam logic [15:0] S0_STRT = 16'h0002;
    localparam logic [15:0] S0_INIT = 16'h0001;

    localparam logic [15:0] S0_CMD_SET = S0_INIT | S0_STRT | S0_STOP | S0_TDMD;
    localparam logic [15:0] S0_W1C     = S0_IDON | S0_TINT | S0_RINT | S0_MERR |
                                         S0_MISS | S0_CERR | S0_BABL;
    localparam logic [15:0] S0_ERR_SRC = S0_BABL | S0_CERR | S0_MISS | S0_MERR;
    localparam logic [15:0] S0_INT_SRC = S0_BABL | S0_MISS | S0_MERR | S0_RINT |
                                         S0_TINT | S0_IDON;

    localparam logic [15:0] MODE_NO_TX = 16'h0002;
    localparam logic [15:0] MODE_NO_RX = 16'h0001;

    typedef struct packed {
        kind_t       kind;
        logic        port;
        logic [15:0] write_data;
        logic [1:0]  event_status;
    } in_word_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq;
        logic        start_transmit;
        logic        init_fetch;
        logic [23:0] init_address;
        logic        receiver_on;
        logic        transmitter_on;
    } out_word_t;

endpackage

`default_nettype wire

/* hdl/lance_control_status_registers.sv */
// LANCE-style control/status register file.
// in channel (in_valid / in_stall / in_word): one word per bus read, bus write,
//   receive-engine event or transmit-engine event. Taken when in_valid is high
//   and in_stall is low.
// out channel (out_valid / out_stall / out_word): exactly one result word per
//   input word, in order. Taken when out_valid is high and out_stall is low.
// cfg channel (cfg_valid / cfg_ready / cfg_data): the init block mode word,
//   latched into the mode register when INIT takes effect. cfg_ready is always
//   high; write only while the block is idle.
// Each result is registered, in the skid register if the output one is stalled.
// Throughput: one word per cycle while in_stall is low; each word's register
//   update is a single read-modify-write of the CSR flops in the accepting cycle.
// When the receiver stalls, the output register holds its word and a skid
//   register takes one more; in_stall rises only once both are full.
// Reset: CSR0 reads STOP only, the pointer, CSR1..CSR3, the mode word and the
//   initialized flag clear, and both channels come up empty.
`default_nettype none

module lance_control_status_registers (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire lcsr_pkg::in_word_t in_word,
    output logic                 out_valid,
    input  wire                  out_stall,
    output lcsr_pkg::out_word_t  out_word,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [15:0]           cfg_data
);

    logic [1:0]  ptr_reg, ptr_next;
    logic [15:0] csr0_reg, csr0_next;
    logic [15:0] csr1_reg, csr1_next;
    logic [7:0]  csr2_reg, csr2_next;
    logic [2:0]  csr3_reg, csr3_next;
    logic        init_done_reg, init_done_next;
    logic [15:0] mode_reg, mode_next;
    logic [15:0] mode_word_reg;

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    lcsr_pkg::out_word_t out_word_reg, out_word_next;
    lcsr_pkg::out_word_t skid_word_reg, skid_word_next;

    lcsr_pkg::out_word_t res;
    logic                accept;
    logic                out_take;

    // CSR0 write scratch
    logic [15:0] s;
    logic [15:0] st;
    logic        stopped;
    logic        init_now;
    logic        tx_pulse;
    logic        fetch_pulse;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    always_comb
    begin
        ptr_next       = ptr_reg;
        csr0_next      = csr0_reg;
        csr1_next      = csr1_reg;
        csr2_next      = csr2_reg;
        csr3_next      = csr3_reg;
        init_done_next = init_done_reg;
        mode_next      = mode_reg;
        tx_pulse       = 1'b0;
        fetch_pulse    = 1'b0;
        init_now       = 1'b0;
        stopped        = (csr0_reg & lcsr_pkg::S0_STOP) != 16'h0;
        s              = csr0_reg;
        st             = csr0_reg;
        res            = '0;

        unique case (in_word.kind)
            lcsr_pkg::KIND_READ:
            begin
                if (in_word.port == lcsr_pkg::PORT_ADDR)
                begin
                    res.read_data = {14'h0, ptr_reg};
                end
                else
                begin
                    unique case (ptr_reg)
                        lcsr_pkg::CSR0:
                        begin
                            res.read_data = csr0_reg;
                            if ((csr0_reg & lcsr_pkg::S0_ERR_SRC) != 16'h0)
                                res.read_data = csr0_reg | lcsr_pkg::S0_ERR;
                        end
                        lcsr_pkg::CSR1: res.read_data = csr1_reg;
                        lcsr_pkg::CSR2: res.read_data = {8'h0, csr2_reg};
                        lcsr_pkg::CSR3: res.read_data = {13'h0, csr3_reg};
                    endcase
                end
            end
            lcsr_pkg::KIND_WRITE:
            begin
                if (in_word.port == lcsr_pkg::PORT_ADDR)
                begin
                    ptr_next = in_word.write_data[1:0];
                end
                else
                begin
                    unique case (ptr_reg)
                        lcsr_pkg::CSR0:
                        begin
                            s = (csr0_reg & ~lcsr_pkg::S0_INEA)
                                | (in_word.write_data & lcsr_pkg::S0_INEA);
                            s = s | (in_word.write_data & lcsr_pkg::S0_CMD_SET);
                            s = s & ~(in_word.write_data & lcsr_pkg::S0_W1C);
                            s = s & ~lcsr_pkg::S0_ERR;
                            st = s;
                            init_now = ((s & lcsr_pkg::S0_INIT) != 16'h0)
                                && ((csr0_reg & lcsr_pkg::S0_INIT) == 16'h0);
                            if (((s & lcsr_pkg::S0_STOP) != 16'h0) && !stopped)
                            begin
                                st        = lcsr_pkg::S0_STOP;
                                csr3_next = 3'h0;
                            end
                            else if (((s & lcsr_pkg::S0_STRT) != 16'h0)
                                && ((csr0_reg & lcsr_pkg::S0_STRT) == 16'h0)
                                && ((csr0_reg & (lcsr_pkg::S0_STOP
                                    | lcsr_pkg::S0_INIT)) != 16'h0))
                            begin
                                st = s & ~lcsr_pkg::S0_STOP;
                                if (init_now)
                                begin
                                    mode_next      = mode_word_reg;
                                    fetch_pulse    = 1'b1;
                                    init_done_next = 1'b1;
                                end
                                // enables follow the mode word, freshly latched if INIT is new
                                if ((mode_next & lcsr_pkg::MODE_NO_TX) == 16'h0)
                                    st = st | lcsr_pkg::S0_TXON;
                                if ((mode_next & lcsr_pkg::MODE_NO_RX) == 16'h0)
                                    st = st | lcsr_pkg::S0_RXON;
                                if (init_now)
                                    st = st | lcsr_pkg::S0_IDON;
                            end
                            else if (init_now && stopped)
                            begin
                                mode_next      = mode_word_reg;
                                fetch_pulse    = 1'b1;
                                init_done_next = 1'b1;
                                csr3_next      = 3'h0;
                                st = (s | lcsr_pkg::S0_IDON) & ~(lcsr_pkg::S0_RXON
                                    | lcsr_pkg::S0_TXON | lcsr_pkg::S0_STOP);
                            end
                            tx_pulse = ((st & lcsr_pkg::S0_STRT) != 16'h0)
                                && init_done_next
                                && ((st & lcsr_pkg::S0_TDMD) != 16'h0)
                                && ((st & lcsr_pkg::S0_TXON) != 16'h0);
                            csr0_next = st & ~lcsr_pkg::S0_TDMD;
                        end
                        lcsr_pkg::CSR1:
                            if (stopped)
                                csr1_next = {in_word.write_data[15:1], 1'b0};
                        lcsr_pkg::CSR2:
                            if (stopped)
                                csr2_next = in_word.write_data[7:0];
                        lcsr_pkg::CSR3:
                            if (stopped)
                                csr3_next = in_word.write_data[2:0];
                    endcase
                end
            end
            lcsr_pkg::KIND_RX:
            begin
                if ((csr0_reg & lcsr_pkg::S0_RXON) != 16'h0)
                begin
                    unique case (in_word.event_status)
                        lcsr_pkg::EV_DONE:  csr0_next = csr0_reg | lcsr_pkg::S0_RINT;
                        lcsr_pkg::EV_MISS:  csr0_next = csr0_reg | lcsr_pkg::S0_MISS;
                        lcsr_pkg::EV_ABORT: csr0_next = csr0_reg & ~lcsr_pkg::S0_RXON;
                        default:            csr0_next = csr0_reg;
                    endcase
                end
            end
            lcsr_pkg::KIND_TX:
            begin
                if ((csr0_reg & lcsr_pkg::S0_TXON) != 16'h0)
                begin
                    unique case (in_word.event_status)
                        lcsr_pkg::EV_DONE:  csr0_next = csr0_reg | lcsr_pkg::S0_TINT;
                        lcsr_pkg::EV_ABORT: csr0_next = (csr0_reg & ~lcsr_pkg::S0_TXON)
                                                        | lcsr_pkg::S0_TINT;
                        default:            csr0_next = csr0_reg;
                    endcase
                end
            end
        endcase

        // interrupt summary
        csr0_next = csr0_next & ~lcsr_pkg::S0_INTR;
        if ((csr0_next & lcsr_pkg::S0_INT_SRC) != 16'h0)
            csr0_next = csr0_next | lcsr_pkg::S0_INTR;

        res.irq            = ((csr0_next & lcsr_pkg::S0_INTR) != 16'h0)
                             && ((csr0_next & lcsr_pkg::S0_INEA) != 16'h0);
        res.start_transmit = tx_pulse;
        res.init_fetch     = fetch_pulse;
        res.init_address   = {csr2_next, csr1_next};
        res.receiver_on    = (csr0_next & lcsr_pkg::S0_RXON) != 16'h0;
        res.transmitter_on = (csr0_next & lcsr_pkg::S0_TXON) != 16'h0;
    end

    // output register plus skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_word_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= 2'h0;
            csr0_reg       <= lcsr_pkg::S0_STOP;
            csr1_reg       <= 16'h0;
            csr2_reg       <= 8'h0;
            csr3_reg       <= 3'h0;
            init_done_reg  <= 1'b0;
            mode_reg       <= 16'h0;
            mode_word_reg  <= 16'h0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ptr_reg       <= ptr_next;
                csr0_reg      <= csr0_next;
                csr1_reg      <= csr1_next;
                csr2_reg      <= csr2_next;
                csr3_reg      <= csr3_next;
                init_done_reg <= init_done_next;
                mode_reg      <= mode_next;
            end
            if (cfg_valid && cfg_ready)
                mode_word_reg <= cfg_data;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule

`default_nettype wire

/* hdl/lcsr_checker.sv */
`default_nettype none

module lcsr_checker (
    input wire                       clk,
    input wire                       rst_n,
    input wire                       in_valid,
    input wire                       in_stall,
    input wire lcsr_pkg::in_word_t   in_word,
    input wire                       out_valid,
    input wire                       out_stall,
    input wire lcsr_pkg::out_word_t  out_word
);

    // a stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_word))
        else $error("input word changed while stalled");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // transmit demand only goes out with the transmitter enabled
    a_tx_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.start_transmit |-> out_word.transmitter_on)
        else $error("start_transmit with transmitter off");

    // input back-pressure only once the output side holds a word
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("in_stall with empty output");

    // both channels are empty once reset has been sampled
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("channel not empty after reset");

endmodule

bind lance_control_status_registers lcsr_checker u_lcsr_checker (.*);

`default_nettype wire
